@@ sv/booth_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the radix-2 Booth multiplier.
// No dependencies; every other file in this block refers to it by scoped names.
package booth_pkg;

  // Operand width the Booth engine works on.
  localparam int WIDTH   = 16;
  // Widths of the channel fields.
  localparam int FIELD_W = 16;
  localparam int PROD_W  = 32;
  // The step counter must be able to hold WIDTH itself.
  localparam int CNT_W   = $clog2(WIDTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } booth_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture operands, clear accumulator and previous bit
    logic step;     // one add/subtract and arithmetic shift
    logic publish;  // move {A, Q} into the output register
  } booth_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_full; // output register holds a result not yet transferred
  } booth_stat_t;

endpackage

@@ sv/booth_in_if.sv @@
`timescale 1ns / 1ps
// Operand channel: valid/ready handshake with multiplicand and multiplier.
// Depends on booth_pkg for the field width.
interface booth_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [booth_pkg::FIELD_W-1:0]  multiplicand;
  logic signed [booth_pkg::FIELD_W-1:0]  multiplier;

  modport source (output valid, output multiplicand, output multiplier, input ready);
  modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

@@ sv/booth_out_if.sv @@
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying the signed product.
// Depends on booth_pkg for the product width.
interface booth_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [booth_pkg::PROD_W-1:0]  product;

  modport source (output valid, output product, input ready);
  modport sink   (input valid, input product, output ready);
endinterface

@@ sv/booth_radix2_multiplier.sv @@
`timescale 1ns / 1ps
// Top level of the radix-2 Booth signed multiplier.
// Depends on booth_pkg, booth_in_if, booth_out_if, booth_ctrl and booth_dp.
//
//   port     dir  payload                              transfer
//   in_ch    in   multiplicand[15:0], multiplier[15:0]  valid & ready
//   out_ch   out  product[31:0]                         valid & ready
//
// Each product runs as a load, WIDTH add/shift steps through the single
// WIDTH-bit adder, and a publish that moves {A, Q} into the output register.
// The output register lets the next item load and run while a result waits;
// only the publish cycle stalls until that register is free.
// Reset is synchronous and active low; it clears the controller and the
// output valid flag, and the block is ready in the first cycle after it.
module booth_radix2_multiplier (
  input  logic        clk,
  input  logic        rst_n,
  booth_in_if.sink    in_ch,
  booth_out_if.source out_ch
);

  booth_pkg::booth_cmd_t  cmd;
  booth_pkg::booth_stat_t stat;

  booth_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  booth_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_multiplicand (in_ch.multiplicand),
    .in_multiplier   (in_ch.multiplier),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_product     (out_ch.product)
  );

endmodule

@@ sv/booth_ctrl.sv @@
`timescale 1ns / 1ps
// Controller for the Booth multiplier: sequences load, WIDTH steps and publish.
// Depends on booth_pkg for the state type, command and status structs.
module booth_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   out_ready,
  input  booth_pkg::booth_stat_t stat,
  output booth_pkg::booth_cmd_t  cmd
);

  booth_pkg::booth_state_t    state_r, state_nxt;
  logic [booth_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= booth_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.publish = 1'b0;
    case (state_r)
      booth_pkg::ST_IDLE: begin
        // No transfer is offered while reset is held.
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          cnt_nxt   = booth_pkg::CNT_W'(booth_pkg::WIDTH);
          state_nxt = booth_pkg::ST_RUN;
        end
      end
      booth_pkg::ST_RUN: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == booth_pkg::CNT_W'(1)) begin
          state_nxt = booth_pkg::ST_FINISH;
        end
      end
      booth_pkg::ST_FINISH: begin
        // The output register is free, or its result transfers this cycle.
        if (!stat.out_full || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = booth_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = booth_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/booth_dp.sv @@
`timescale 1ns / 1ps
// Datapath for the Booth multiplier: A, Q and previous-bit registers, one
// WIDTH-bit adder/subtractor, and the output register. Depends on booth_pkg.
module booth_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  booth_pkg::booth_cmd_t                cmd,
  output booth_pkg::booth_stat_t               stat,
  input  logic signed [booth_pkg::FIELD_W-1:0] in_multiplicand,
  input  logic signed [booth_pkg::FIELD_W-1:0] in_multiplier,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [booth_pkg::PROD_W-1:0]  out_product
);

  logic [booth_pkg::WIDTH-1:0]  m_r;
  logic [booth_pkg::WIDTH-1:0]  a_r, a_nxt;
  logic [booth_pkg::WIDTH-1:0]  q_r, q_nxt;
  logic                         prev_r, prev_nxt;
  logic [booth_pkg::WIDTH-1:0]  a_sum;
  logic [booth_pkg::PROD_W-1:0] product_r;
  logic                         out_valid_r, out_valid_nxt;

  always_comb begin
    // Booth pair 10 subtracts M, 01 adds M, 00 and 11 leave A alone.
    a_sum = a_r;
    if (q_r[0] && !prev_r) begin
      a_sum = a_r - m_r;
    end else if (!q_r[0] && prev_r) begin
      a_sum = a_r + m_r;
    end
    a_nxt    = {a_sum[booth_pkg::WIDTH-1], a_sum[booth_pkg::WIDTH-1:1]};
    q_nxt    = {a_sum[0], q_r[booth_pkg::WIDTH-1:1]};
    prev_nxt = q_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r       <= '0;
      a_r       <= '0;
      q_r       <= '0;
      prev_r    <= 1'b0;
      product_r <= '0;
    end else begin
      if (cmd.load) begin
        m_r    <= booth_pkg::WIDTH'(in_multiplicand);
        q_r    <= booth_pkg::WIDTH'(in_multiplier);
        a_r    <= '0;
        prev_r <= 1'b0;
      end else if (cmd.step) begin
        a_r    <= a_nxt;
        q_r    <= q_nxt;
        prev_r <= prev_nxt;
      end
      if (cmd.publish) begin
        product_r <= booth_pkg::PROD_W'({a_r, q_r});
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign stat.out_full = out_valid_r;
  assign out_valid     = out_valid_r;
  assign out_product   = product_r;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for booth_radix2_multiplier: operands go in over one channel,
// and each product is checked against a bit-level Booth predictor.
// Depends on booth_pkg, booth_in_if, booth_out_if and the multiplier top level.
module tb;

  localparam int W      = booth_pkg::WIDTH;
  localparam int FW     = booth_pkg::FIELD_W;
  localparam int PW     = booth_pkg::PROD_W;
  localparam int N_RAND = 460;

  typedef struct {
    logic signed [FW-1:0] mcand;
    logic signed [FW-1:0] mplier;
    logic signed [PW-1:0] product;
  } booth_job_t;

  logic clk;
  logic rst_n;

  booth_in_if  in_ch ();
  booth_out_if out_ch ();

  booth_radix2_multiplier dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  booth_job_t pending_products[$];
  int         mismatch_count;
  int         sender_idle_pct;
  int         receiver_stall_pct;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Radix-2 Booth recoding over the low W bits of each operand. The add and
  // subtract wrap at W bits, so the most negative multiplicand behaves as the
  // hardware does rather than as true multiplication.
  function automatic logic [PW-1:0] booth_product(logic [FW-1:0] mcand, logic [FW-1:0] mplier);
    logic [W-1:0]  m;
    logic [W-1:0]  acc;
    logic [W-1:0]  q;
    logic          prev;
    logic          lsb;
    logic [PW-1:0] res;
    m    = mcand[W-1:0];
    q    = mplier[W-1:0];
    acc  = '0;
    prev = 1'b0;
    for (int i = 0; i < W; i++) begin
      lsb = q[0];
      if (lsb && !prev) begin
        acc = acc - m;
      end else if (!lsb && prev) begin
        acc = acc + m;
      end
      prev = lsb;
      q    = {acc[0], q[W-1:1]};
      acc  = {acc[W-1], acc[W-1:1]};
    end
    res = '0;
    res[2*W-1:0] = {acc, q};
    return res;
  endfunction

  // Mostly uniform values, with the corner values mixed in often.
  function automatic logic [FW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(FW-1){1'b0}}};
      1: return {1'b0, {(FW-1){1'b1}}};
      2: return {FW{1'b1}};
      3: return FW'($urandom_range(0, 2));
      default: return FW'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_operands(logic [FW-1:0] mcand, logic [FW-1:0] mplier);
    booth_job_t job;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.multiplicand <= FW'($urandom);
      in_ch.multiplier   <= FW'($urandom);
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.multiplicand <= mcand;
    in_ch.multiplier   <= mplier;
    do @(posedge clk); while (!in_ch.ready);
    job.mcand   = mcand;
    job.mplier  = mplier;
    job.product = booth_product(mcand, mplier);
    pending_products.push_back(job);
    @(negedge clk);
  endtask

  task automatic test_directed();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_operands(16'h0000, 16'h0000);
    send_operands(16'h7fff, 16'h7fff);
    // The most negative multiplicand wraps inside the accumulator.
    send_operands(16'h8000, 16'h8000);
    send_operands(16'h8000, 16'h7fff);
    send_operands(16'h7fff, 16'h8000);
    send_operands(16'h8000, 16'hffff);
    send_operands(16'hffff, 16'h8000);
    send_operands(16'h8000, 16'h0001);
    send_operands(16'h0001, 16'h8000);
    send_operands(16'hffff, 16'hffff);
    send_operands(16'h0001, 16'hffff);
    send_operands(16'hffff, 16'h0001);
    send_operands(16'h0000, 16'h8000);
    send_operands(16'h8000, 16'h0000);
    send_operands(16'h5555, 16'haaaa);
    send_operands(16'haaaa, 16'h5555);
    send_operands(16'h0001, 16'h0001);
    send_operands(16'h1234, 16'hfedc);
  endtask

  task automatic run_random(int idle_pct, int stall_pct, int count);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_operands(pick_operand(), pick_operand());
  endtask

  task automatic test_random_no_idle();
    run_random(0, 0, N_RAND);
  endtask

  task automatic test_random_sender_idle();
    run_random(58, 0, N_RAND);
  endtask

  task automatic test_random_receiver_stall();
    run_random(0, 58, N_RAND);
  endtask

  task automatic test_random_both_idle();
    run_random(10, 10, N_RAND);
  endtask

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    booth_job_t job;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_products.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected product transfer: got %0d", out_ch.product);
      end else begin
        job = pending_products.pop_front();
        if (out_ch.product !== job.product) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("product mismatch for %0d * %0d: expected %0d, got %0d",
                     job.mcand, job.mplier, job.product, out_ch.product);
        end
      end
    end
  end

  initial begin
    int waited;
    mismatch_count     = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.multiplicand = '0;
    in_ch.multiplier   = '0;
    out_ch.ready       = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    in_ch.valid <= 1'b0;

    waited = 0;
    while (pending_products.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * W + 4) @(posedge clk);

    if (mismatch_count == 0 && pending_products.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // The worst case stays well inside this limit, which leaves a wide margin.
  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
